[rtl/cfp_pkg.sv]
// shared constants, types and the crc byte update of the frame parser
package cfp_pkg;

   localparam int BYTE_W            = 8;
   localparam int CRC_W             = 16;
   localparam int MAX_PAYLOAD_BYTES = 64;
   localparam int BUFFER_BYTES      = 256;
   localparam int POS_W             = $clog2(BUFFER_BYTES + 1);
   // wide enough for the byte position and for six plus any payload length
   localparam int CMP_W             = ((POS_W > BYTE_W + 1) ? POS_W : BYTE_W + 1) + 1;

   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
   localparam logic [CRC_W-1:0] CRC_TOP  = 16'h8000;
   localparam logic [CRC_W-1:0] CRC_INIT = 16'h0000;

   localparam logic [BYTE_W-1:0] START_FIRST_RESET  = 8'hAA;
   localparam logic [BYTE_W-1:0] START_SECOND_RESET = 8'h55;

   // frame layout positions
   localparam int POS_START_FIRST  = 0;
   localparam int POS_START_SECOND = 1;
   localparam int POS_LENGTH       = 2;
   localparam int POS_TYPE         = 3;
   localparam int POS_PAYLOAD      = 4;
   localparam int HEADER_BYTES     = 2;
   localparam int MIN_FRAME_BYTES  = 6;

   typedef enum logic [1:0] {
      CSR_START_FIRST  = 2'd0,
      CSR_START_SECOND = 2'd1,
      CSR_CRC_ORDER    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_START_ERR = 2'd1,
      STATUS_LEN_ERR   = 2'd2,
      STATUS_CRC_ERR   = 2'd3
   } status_type;

   typedef enum logic {
      KIND_ECHO   = 1'b0,
      KIND_REPORT = 1'b1
   } kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] start_byte_first;
      logic [BYTE_W-1:0] start_byte_second;
      logic              crc_high_byte_first;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      kind_type          item_kind;
      logic [BYTE_W-1:0] payload_byte;
      logic [BYTE_W-1:0] payload_index;
      status_type        frame_status;
      logic [BYTE_W-1:0] frame_type;
      logic [BYTE_W-1:0] length_field;
      logic [CRC_W-1:0]  received_crc;
   } result_type;

   // crc-16/xmodem, msb first, one byte
   function automatic logic [CRC_W-1:0] crc_add_byte(input logic [CRC_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
      for (int k = 0; k < BYTE_W; k++) begin
         if ((c & CRC_TOP) != '0) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

[rtl/cfp_if.sv]
// channel interfaces of the frame parser: received bytes, results, register writes
interface cfp_req_if import cfp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   logic              end_of_buffer;

   modport source (output valid, output rx_byte, output end_of_buffer, input ready);
   modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

interface cfp_rsp_if import cfp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              item_kind;
   logic [BYTE_W-1:0] payload_byte;
   logic [BYTE_W-1:0] payload_index;
   logic [1:0]        frame_status;
   logic [BYTE_W-1:0] frame_type;
   logic [BYTE_W-1:0] length_field;
   logic [CRC_W-1:0]  received_crc;

   modport source (output valid, output item_kind, output payload_byte,
                   output payload_index, output frame_status, output frame_type,
                   output length_field, output received_crc, input ready);
   modport sink   (input valid, input item_kind, input payload_byte,
                   input payload_index, input frame_status, input frame_type,
                   input length_field, input received_crc, output ready);
endinterface

interface cfp_csr_if import cfp_pkg::*; ();
   logic              valid;
   logic              ready;
   csr_index_type     index;
   logic [BYTE_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/cfp_frame_engine.sv]
// per-buffer frame state, crc update, echo and end-of-buffer report
module cfp_frame_engine import cfp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [BYTE_W-1:0] rx_byte,
   input  logic              end_of_buffer,
   input  cfg_type           cfg,
   output result_type        result
);

   logic [POS_W-1:0]  pos_ff,    pos_in;
   logic [CRC_W-1:0]  crc_ff,    crc_in;
   logic              mism_ff,   mism_in;
   logic [BYTE_W-1:0] len_ff,    len_in;
   logic [BYTE_W-1:0] type_ff,   type_in;
   logic [CRC_W-1:0]  rcrc_ff,   rcrc_in;

   logic [CMP_W-1:0]  p;
   logic [CMP_W-1:0]  n;
   logic [CMP_W-1:0]  pl_ext;
   logic [CMP_W-1:0]  echo_idx_full;
   logic [BYTE_W-1:0] pl;
   logic              in_range;
   logic              len_ok;
   logic              echo;
   logic [POS_W-1:0]  pos_new;
   logic [CRC_W-1:0]  crc_new;
   logic              mism_new;
   logic [BYTE_W-1:0] len_new;
   logic [BYTE_W-1:0] type_new;
   logic [CRC_W-1:0]  rcrc_new;
   status_type        status;

   always_comb begin
      p        = CMP_W'(pos_ff);
      in_range = p < CMP_W'(BUFFER_BYTES);

      len_new  = (in_range && p == CMP_W'(POS_LENGTH)) ? rx_byte : len_ff;
      type_new = (in_range && p == CMP_W'(POS_TYPE))   ? rx_byte : type_ff;
      mism_new = mism_ff
               | (in_range && p == CMP_W'(POS_START_FIRST)  && rx_byte != cfg.start_byte_first)
               | (in_range && p == CMP_W'(POS_START_SECOND) && rx_byte != cfg.start_byte_second);

      pl     = len_new - BYTE_W'(HEADER_BYTES);
      pl_ext = CMP_W'(pl);
      len_ok = (len_new >= BYTE_W'(HEADER_BYTES)) && (CMP_W'(pl) <= CMP_W'(MAX_PAYLOAD_BYTES));

      crc_new       = crc_ff;
      rcrc_new      = rcrc_ff;
      echo          = 1'b0;
      echo_idx_full = p - CMP_W'(POS_PAYLOAD);
      if (in_range) begin
         if (p < CMP_W'(POS_PAYLOAD)) begin
            crc_new = crc_add_byte(crc_ff, rx_byte);
         end else if (p < CMP_W'(POS_PAYLOAD) + pl_ext) begin
            crc_new = crc_add_byte(crc_ff, rx_byte);
            echo    = len_ok;
         end else if (p == CMP_W'(POS_PAYLOAD) + pl_ext) begin
            if (cfg.crc_high_byte_first) begin
               rcrc_new = {rx_byte, rcrc_ff[BYTE_W-1:0]};
            end else begin
               rcrc_new = {rcrc_ff[CRC_W-1:BYTE_W], rx_byte};
            end
         end else if (p == CMP_W'(POS_PAYLOAD + 1) + pl_ext) begin
            if (cfg.crc_high_byte_first) begin
               rcrc_new = {rcrc_ff[CRC_W-1:BYTE_W], rx_byte};
            end else begin
               rcrc_new = {rx_byte, rcrc_ff[BYTE_W-1:0]};
            end
         end
      end
      pos_new = in_range ? pos_ff + POS_W'(1) : pos_ff;

      // status checks in priority order
      n = CMP_W'(pos_new);
      if (n < CMP_W'(MIN_FRAME_BYTES)) begin
         status = STATUS_LEN_ERR;
      end else if (mism_new) begin
         status = STATUS_START_ERR;
      end else if (!len_ok) begin
         status = STATUS_LEN_ERR;
      end else if (n < CMP_W'(MIN_FRAME_BYTES) + pl_ext) begin
         status = STATUS_LEN_ERR;
      end else if (crc_new != rcrc_new) begin
         status = STATUS_CRC_ERR;
      end else begin
         status = STATUS_OK;
      end

      result = '0;
      result.valid = step && (end_of_buffer || echo);
      if (end_of_buffer) begin
         result.item_kind    = KIND_REPORT;
         result.frame_status = status;
         result.frame_type   = type_new;
         result.length_field = len_new;
         result.received_crc = (status == STATUS_OK) ? rcrc_new : '0;
      end else begin
         result.item_kind     = KIND_ECHO;
         result.payload_byte  = rx_byte;
         result.payload_index = echo_idx_full[BYTE_W-1:0];
      end

      pos_in  = pos_ff;
      crc_in  = crc_ff;
      mism_in = mism_ff;
      len_in  = len_ff;
      type_in = type_ff;
      rcrc_in = rcrc_ff;
      if (step) begin
         if (end_of_buffer) begin
            pos_in  = '0;
            crc_in  = CRC_INIT;
            mism_in = 1'b0;
            len_in  = '0;
            type_in = '0;
            rcrc_in = '0;
         end else begin
            pos_in  = pos_new;
            crc_in  = crc_new;
            mism_in = mism_new;
            len_in  = len_new;
            type_in = type_new;
            rcrc_in = rcrc_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         crc_ff  <= CRC_INIT;
         mism_ff <= 1'b0;
         len_ff  <= '0;
         type_ff <= '0;
         rcrc_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         crc_ff  <= crc_in;
         mism_ff <= mism_in;
         len_ff  <= len_in;
         type_ff <= type_in;
         rcrc_ff <= rcrc_in;
      end
   end

endmodule

[rtl/crc16_frame_parser_top.sv]
// top level of the crc-16 frame parser: channels, registers, input and result stages
//
//  channel   dir  word                               notes
//  req_chan  in   rx_byte, end_of_buffer             one received byte per word
//  rsp_chan  out  item_kind, payload/report fields   echo or end-of-buffer report
//  csr_chan  in   index, data                        always ready, write only
//
// one word per cycle sustained while rsp is not stalled; a word that gives a result
// raises rsp valid once it has passed both registers
// (input register, then frame logic into the result register)
// synchronous active-high reset restores the start bytes to 0xaa/0x55, high crc
// byte first, and clears the frame state
// a stalled rsp holds the result register; the input register takes a word while
// empty, or while its own word moves into a result register that is free or being emptied
module crc16_frame_parser_top import cfp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   cfp_req_if.sink    req_chan,
   cfp_rsp_if.source  rsp_chan,
   cfp_csr_if.sink    csr_chan
);

   // configuration registers
   cfg_type cfg_ff, cfg_in;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_eob_ff;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   logic       advance;
   result_type result;

   // register writes; out-of-range indexes are dropped
   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_START_FIRST:  cfg_in.start_byte_first    = csr_chan.data;
            CSR_START_SECOND: cfg_in.start_byte_second   = csr_chan.data;
            CSR_CRC_ORDER:    cfg_in.crc_high_byte_first = csr_chan.data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   // the held word moves into the frame logic when the result slot can take it
   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
      end
   end

   cfp_frame_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .rx_byte       (in_byte_ff),
      .end_of_buffer (in_eob_ff),
      .cfg           (cfg_ff),
      .result        (result)
   );

   // result slot: filled by a word that gives a result, emptied on rsp handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (advance) begin
         rsp_valid_in = result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte_first    <= START_FIRST_RESET;
         cfg_ff.start_byte_second   <= START_SECOND_RESET;
         cfg_ff.crc_high_byte_first <= 1'b1;
         in_valid_ff                <= 1'b0;
         rsp_valid_ff               <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_byte_ff <= req_chan.rx_byte;
         in_eob_ff  <= req_chan.end_of_buffer;
      end
      if (advance && result.valid) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.item_kind     = rsp_data_ff.item_kind;
   assign rsp_chan.payload_byte  = rsp_data_ff.payload_byte;
   assign rsp_chan.payload_index = rsp_data_ff.payload_index;
   assign rsp_chan.frame_status  = rsp_data_ff.frame_status;
   assign rsp_chan.frame_type    = rsp_data_ff.frame_type;
   assign rsp_chan.length_field  = rsp_data_ff.length_field;
   assign rsp_chan.received_crc  = rsp_data_ff.received_crc;

endmodule
